// File: design/dfu_suffix_checker_macros.svh
// Assertion macros shared by the suffix checker's checker module.
// Needs a clk and rst in the scope of each use.
`ifndef DFU_SUFFIX_CHECKER_MACROS_SVH
`define DFU_SUFFIX_CHECKER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DFU_SFX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dfu suffix checker: same-cycle property failed");

// Next-cycle implication, sampled on clk, off during reset.
`define DFU_SFX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dfu suffix checker: next-cycle property failed");

`endif

// File: design/dfu_sfx_pkg.sv
// Shared types, constants and the byte-wise CRC-32 step for the suffix checker.
// No dependencies; all design files but the macro header import this package.
package dfu_sfx_pkg;

  localparam int unsigned WinLen = 16;
  localparam int unsigned CntW   = $clog2(WinLen + 1);
  localparam int unsigned CrcLag = 4;

  localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit   = 32'hFFFF_FFFF;
  localparam logic [7:0]  SfxLength = 8'h10;
  localparam logic [15:0] VersionA  = 16'h0100;
  localparam logic [15:0] VersionB  = 16'h0101;
  localparam logic [7:0]  Sig0      = 8'h55;
  localparam logic [7:0]  Sig1      = 8'h46;
  localparam logic [7:0]  Sig2      = 8'h44;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_TOO_SHORT     = 3'd1,
    ST_BAD_LENGTH    = 3'd2,
    ST_BAD_VERSION   = 3'd3,
    ST_BAD_SIGNATURE = 3'd4,
    ST_CRC_MISMATCH  = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] computed_crc;
    logic [31:0] stored_crc;
  } result_t;

  // Reflected CRC-32 over one byte, eight shift/xor steps.
  function automatic logic [31:0] crc32_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// File: design/dfu_sfx_core.sv
// Tail window, byte count and delayed CRC state, plus the suffix checks.
// Depends on dfu_sfx_pkg.
module dfu_sfx_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  dfu_sfx_pkg::item_t item,
  output dfu_sfx_pkg::result_t result,
  output logic               done
);
  import dfu_sfx_pkg::*;

  logic [7:0]      window      [WinLen];
  logic [7:0]      window_next [WinLen];
  logic [CntW-1:0] seen_count;
  logic [CntW-1:0] seen_next;
  logic [31:0]     crc_reg;
  logic [31:0]     crc_next;
  logic [31:0]     stored;
  logic [15:0]     version;
  status_t         status;

  always_comb begin
    // the byte CrcLag places behind the new one enters the CRC
    crc_next = (seen_count >= CntW'(CrcLag)) ?
               crc32_byte(crc_reg, window[WinLen-CrcLag]) : crc_reg;
    for (int i = 0; i < WinLen - 1; i++) begin
      window_next[i] = window[i+1];
    end
    window_next[WinLen-1] = item.data_byte;
    seen_next = (seen_count < CntW'(WinLen)) ? seen_count + 1'b1 : seen_count;

    stored  = {window_next[15], window_next[14], window_next[13], window_next[12]};
    version = {window_next[7], window_next[6]};

    if (seen_next < CntW'(WinLen)) begin
      status = ST_TOO_SHORT;
    end else if (window_next[11] != SfxLength) begin
      status = ST_BAD_LENGTH;
    end else if (version != VersionA && version != VersionB) begin
      status = ST_BAD_VERSION;
    end else if (window_next[8] != Sig0 || window_next[9] != Sig1 ||
                 window_next[10] != Sig2) begin
      status = ST_BAD_SIGNATURE;
    end else if (crc_next != stored) begin
      status = ST_CRC_MISMATCH;
    end else begin
      status = ST_OK;
    end

    result.status       = status;
    result.computed_crc = crc_next;
    result.stored_crc   = stored;
    done                = step & item.last;
  end

  always_ff @(posedge clk) begin
    if (rst || done) begin
      crc_reg    <= CrcInit;
      seen_count <= '0;
      for (int i = 0; i < WinLen; i++) begin
        window[i] <= '0;
      end
    end else if (step) begin
      crc_reg    <= crc_next;
      seen_count <= seen_next;
      for (int i = 0; i < WinLen; i++) begin
        window[i] <= window_next[i];
      end
    end
  end

endmodule

// File: design/dfu_sfx_out.sv
// Result register on the output channel; tells upstream when it can advance.
// Depends on dfu_sfx_pkg.
module dfu_sfx_out (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load_valid,
  input  dfu_sfx_pkg::result_t load_data,
  output logic                 advance,
  output logic                 result_valid,
  input  logic                 result_stall,
  output dfu_sfx_pkg::result_t result
);
  import dfu_sfx_pkg::*;

  // free when empty or when the held word leaves this edge
  assign advance = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_valid) begin
      result <= load_data;
    end
  end

endmodule

// File: design/dfu_suffix_checker.sv
// DFU suffix checker top level: input register, window/CRC core, result register.
// Takes one image byte per cycle; the final byte's result passes both registers in turn.
// Throughput is one byte per cycle; a stalled result word also holds the input register.
// Reset (rst, synchronous): window zero, count zero, CRC all ones, both registers empty.
// Window, count and CRC also clear after every final byte. Depends on dfu_sfx_pkg.
module dfu_suffix_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  dfu_sfx_pkg::item_t   item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output dfu_sfx_pkg::result_t result
);
  import dfu_sfx_pkg::*;

  // input register
  logic    held_valid;
  item_t   held;
  logic    advance;
  logic    accept;
  logic    step;
  logic    done;
  result_t core_result;

  // hold the word only while the result side cannot move
  assign item_stall = held_valid && !advance;
  assign accept     = item_valid && !item_stall;
  // process the held word whenever the result register can take its outcome
  assign step       = held_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= item;
    end
  end

  // window, count, delayed CRC and suffix checks
  dfu_sfx_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (held),
    .result (core_result),
    .done   (done)
  );

  // only a final byte produces a result word
  dfu_sfx_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (done),
    .load_data    (core_result),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: design/dfu_sfx_checks.sv
// Port-level assertions for the suffix checker, bound to the top level.
// Depends on dfu_sfx_pkg and dfu_suffix_checker_macros.svh.
`include "dfu_suffix_checker_macros.svh"

module dfu_sfx_checks (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_valid,
  input logic                 item_stall,
  input dfu_sfx_pkg::item_t   item,
  input logic                 result_valid,
  input logic                 result_stall,
  input dfu_sfx_pkg::result_t result
);
  import dfu_sfx_pkg::*;

  // a stalled input word stays put
  `DFU_SFX_ASSERT_NEXT(a_hold_item, item_valid && item_stall, item_valid && $stable(item))
  // a stalled result word stays put
  `DFU_SFX_ASSERT_NEXT(a_hold_result, result_valid && result_stall, result_valid && $stable(result))
  // status code stays within the defined set
  `DFU_SFX_ASSERT_NOW(a_status_range, result_valid, result.status <= ST_CRC_MISMATCH)
  // ok means the CRCs agree
  `DFU_SFX_ASSERT_NOW(a_ok_crc, result_valid && result.status == ST_OK, result.computed_crc == result.stored_crc)
  // a mismatch means the CRCs differ
  `DFU_SFX_ASSERT_NOW(a_mismatch_crc, result_valid && result.status == ST_CRC_MISMATCH, result.computed_crc != result.stored_crc)

endmodule

bind dfu_suffix_checker dfu_sfx_checks u_checks (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
